### rtl/core/lcfe_pkg.sv
`default_nettype none

package lcfe_pkg;

   // field widths
   localparam int unsigned COLOR_W    = 32;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned DUR_W      = 24;
   localparam int unsigned DELTA_W    = 16;
   localparam int unsigned ELAPSED_W  = 25;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned PROG_W     = FRAC_W + 1;
   localparam int unsigned KIND_W     = 3;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 40;

   // register reset values
   localparam logic [COLOR_W-1:0] START_COLOR_RST = 32'hFFFF_FFFF;
   localparam logic [COLOR_W-1:0] END_COLOR_RST   = 32'h0000_00FF;
   localparam logic [DUR_W-1:0]   DURATION_RST    = 24'd1000;

   // progress value meaning 1.0
   localparam logic [PROG_W-1:0] PROG_ONE = 17'h1_0000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_COLOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_COLOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION    = 2'd2;

   // event codes
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK       = 3'd0,
      KIND_START      = 3'd1,
      KIND_PAUSE      = 3'd2,
      KIND_STOP       = 3'd3,
      KIND_SHOW_START = 3'd4,
      KIND_SHOW_END   = 3'd5,
      KIND_LOAD       = 3'd6
   } kind_type;

endpackage

`default_nettype wire

### rtl/core/led_color_fade_engine.sv
`default_nettype none

// channel   dir  handshake            payload
// req       in   req_tvalid/tready    tuser: kind; tdata: delta_ticks, new_color
// rsp       out  rsp_tvalid/tready    tdata: red, green, blue, alpha, is_fading
// csr       in   csr_valid/ready      csr_index, csr_data (always ready)
//
// an event goes from accept through the finish state to the result register; a tick that advances
// the fade runs one compare, a 16-step restoring divider for elapsed/duration,
// then one 8x17 multiply per channel; the divider is skipped if progress is already one.
// req_tready is high only when the sequencer is idle; the result register lets
// the next word in while an earlier result waits on rsp_tready.
// reset is synchronous, active high; it loads the register defaults.
module led_color_fade_engine (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input words
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [lcfe_pkg::REQ_DATA_W-1:0] req_tdata,  // delta_ticks, new_color
   input  wire logic [lcfe_pkg::KIND_W-1:0]     req_tuser,  // kind
   // result words
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [lcfe_pkg::RSP_DATA_W-1:0] rsp_tdata,  // red, green, blue, alpha,
                                                            // is_fading, zero pad
   // register writes
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [lcfe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lcfe_pkg::COLOR_W-1:0]    csr_data
);
   import lcfe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_MIX,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [COLOR_W-1:0]     start_color_ff, start_color_in;
   logic [COLOR_W-1:0]     end_color_ff, end_color_in;
   logic [DUR_W-1:0]       duration_ff, duration_in;
   logic                   active_ff, active_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic [COLOR_W-1:0]     shown_ff, shown_in;
   logic [DUR_W-1:0]       rem_ff, rem_in;
   logic [PROG_W-1:0]      prog_ff, prog_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic [DUR_W-1:0]       dur;
   logic [DUR_W:0]         rem_sh;
   logic                   rem_ge;
   logic [CHAN_W-1:0]      chan_s, chan_e, chan_ad, chan_mag, chan_v;
   logic [CHAN_W+PROG_W-1:0] chan_prod;
   logic                   req_fire;
   logic                   rsp_free;
   kind_type               kind;
   logic [DELTA_W-1:0]     delta;
   logic [COLOR_W-1:0]     new_color;

   // unpack the input word
   assign kind      = kind_type'(req_tuser);
   assign delta     = req_tdata[DELTA_W-1:0];
   assign new_color = req_tdata[REQ_DATA_W-1:DELTA_W];

   // zero duration counts as one
   assign dur = (duration_ff == '0) ? {{(DUR_W-1){1'b0}}, 1'b1} : duration_ff;

   // divider step: shift remainder, compare and subtract
   assign rem_sh = {rem_ff, 1'b0};
   assign rem_ge = (rem_sh >= {1'b0, dur});

   // channel blend, one channel per cycle, lowest byte first
   assign chan_s    = start_color_ff[{cnt_ff[1:0], 3'b000} +: CHAN_W];
   assign chan_e    = end_color_ff[{cnt_ff[1:0], 3'b000} +: CHAN_W];
   assign chan_ad   = (chan_s >= chan_e) ? (chan_s - chan_e) : (chan_e - chan_s);
   assign chan_prod = {{PROG_W{1'b0}}, chan_ad} * {{CHAN_W{1'b0}}, prog_ff};
   assign chan_mag  = chan_prod[FRAC_W +: CHAN_W];
   assign chan_v    = (chan_s >= chan_e) ? (chan_s - chan_mag) : (chan_s + chan_mag);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // sequencer and datapath next values
   always_comb begin
      state_in       = state_ff;
      start_color_in = start_color_ff;
      end_color_in   = end_color_ff;
      duration_in    = duration_ff;
      active_in      = active_ff;
      elapsed_in     = elapsed_ff;
      shown_in       = shown_ff;
      rem_in         = rem_ff;
      prog_in        = prog_ff;
      cnt_in         = cnt_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_tdata_in   = rsp_tdata_ff;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_START_COLOR: start_color_in = csr_data;
            CSR_END_COLOR:   end_color_in   = csr_data;
            CSR_DURATION:    duration_in    = csr_data[DUR_W-1:0];
            default: ;
         endcase
      end

      // result word taken
      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_FINISH;
               unique case (kind)
                  KIND_TICK: begin
                     if (active_ff && ({1'b0, dur} > elapsed_ff)) begin
                        elapsed_in = elapsed_ff + {{(ELAPSED_W-DELTA_W){1'b0}}, delta};
                        state_in   = ST_SETUP;
                     end else if (active_ff) begin
                        shown_in   = end_color_ff;
                        active_in  = 1'b0;
                        elapsed_in = '0;
                     end
                  end
                  KIND_START:      active_in = 1'b1;
                  KIND_PAUSE:      active_in = 1'b0;
                  KIND_STOP: begin
                     active_in  = 1'b0;
                     elapsed_in = '0;
                  end
                  KIND_SHOW_START: shown_in = start_color_ff;
                  KIND_SHOW_END:   shown_in = end_color_ff;
                  KIND_LOAD:       shown_in = new_color;
                  default: ;
               endcase
            end
         end
         // progress saturates at one, else divide
         ST_SETUP: begin
            cnt_in = '0;
            if (elapsed_ff >= {1'b0, dur}) begin
               prog_in  = PROG_ONE;
               state_in = ST_MIX;
            end else begin
               rem_in   = elapsed_ff[DUR_W-1:0];
               prog_in  = '0;
               state_in = ST_DIV;
            end
         end
         // one quotient bit per cycle
         ST_DIV: begin
            rem_in  = rem_ge ? DUR_W'(rem_sh - {1'b0, dur}) : rem_sh[DUR_W-1:0];
            prog_in = {prog_ff[PROG_W-2:0], rem_ge};
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               cnt_in   = '0;
               state_in = ST_MIX;
            end
         end
         // shift blended channels in from the top
         ST_MIX: begin
            shown_in = {chan_v, shown_ff[COLOR_W-1:CHAN_W]};
            cnt_in   = cnt_ff + 4'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ST_FINISH;
            end
         end
         // load the result register once it is free
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {7'b0, active_ff, shown_ff[7:0], shown_ff[15:8],
                                shown_ff[23:16], shown_ff[31:24]};
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         start_color_ff <= START_COLOR_RST;
         end_color_ff   <= END_COLOR_RST;
         duration_ff    <= DURATION_RST;
         active_ff      <= 1'b0;
         elapsed_ff     <= '0;
         shown_ff       <= END_COLOR_RST;
         rem_ff         <= '0;
         prog_ff        <= '0;
         cnt_ff         <= '0;
         rsp_tvalid_ff  <= 1'b0;
         rsp_tdata_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         start_color_ff <= start_color_in;
         end_color_ff   <= end_color_in;
         duration_ff    <= duration_in;
         active_ff      <= active_in;
         elapsed_ff     <= elapsed_in;
         shown_ff       <= shown_in;
         rem_ff         <= rem_in;
         prog_ff        <= prog_in;
         cnt_ff         <= cnt_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         rsp_tdata_ff   <= rsp_tdata_in;
      end
   end

endmodule

`default_nettype wire

### dv/led_color_fade_engine_tb.sv
`default_nettype none

module led_color_fade_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcfe_pkg::*;

   localparam logic [KIND_W-1:0]    KIND_SPARE  = 3'd7;   // unused event code
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = 2'd3;   // unmapped register index
   localparam int unsigned          QUIET_LIMIT = 5000;
   localparam int unsigned          HOLD_CYCLES = 400;
   localparam int unsigned          PHASES      = 8;
   localparam int unsigned          RANDOM_PER_PHASE = 124;

   // one control event as queued for the driver
   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [DELTA_W-1:0] delta;
      logic [COLOR_W-1:0] color;
   } fade_event_type;

   // result word fields, red in the lowest bits
   typedef struct packed {
      logic              fading;
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [COLOR_W-1:0]    csr_data = '0;

   led_color_fade_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predictor copy of registers and state
   logic [COLOR_W-1:0]   cfg_start = START_COLOR_RST;
   logic [COLOR_W-1:0]   cfg_end   = END_COLOR_RST;
   logic [DUR_W-1:0]     cfg_dur   = DURATION_RST;
   logic                 fading    = 1'b0;
   logic [ELAPSED_W-1:0] run_ms    = '0;
   logic [COLOR_W-1:0]   shown     = END_COLOR_RST;

   fade_event_type event_q[$];
   pixel_word_type pixel_q[$];
   fade_event_type next_ev;
   pixel_word_type seen;
   pixel_word_type want;
   int unsigned n_queued = 0;
   int unsigned n_taken = 0;
   int unsigned phase_made = 0;
   int unsigned mismatches = 0;
   int unsigned quiet = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_asks = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   logic        req_took = 1'b0;

   // one channel of the linear blend, step truncated toward zero
   function automatic logic [CHAN_W-1:0] blend_chan(logic [CHAN_W-1:0] s,
                                                    logic [CHAN_W-1:0] e,
                                                    logic [PROG_W-1:0] prog);
      logic [CHAN_W:0] span;
      logic [25:0]     prod;
      int              v;
      span = (s >= e) ? 9'(s) - 9'(e) : 9'(e) - 9'(s);
      prod = 26'(span) * 26'(prog);
      v = (s >= e) ? int'(s) - int'(prod >> FRAC_W) : int'(s) + int'(prod >> FRAC_W);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[CHAN_W-1:0];
   endfunction

   // apply one event to the predicted state and return the shown word
   function automatic pixel_word_type fade_step(logic [KIND_W-1:0] kind,
                                                logic [DELTA_W-1:0] delta,
                                                logic [COLOR_W-1:0] color);
      logic [DUR_W-1:0]  dur_eff;
      logic [40:0]       quot;
      logic [PROG_W-1:0] prog;
      pixel_word_type    w;
      dur_eff = (cfg_dur == '0) ? DUR_W'(1) : cfg_dur;
      case (kind)
         KIND_TICK: begin
            if (fading && run_ms < ELAPSED_W'(dur_eff)) begin
               run_ms = run_ms + ELAPSED_W'(delta);
               quot = {run_ms, 16'h0} / 41'(dur_eff);
               prog = (quot > 41'(PROG_ONE)) ? PROG_ONE : quot[PROG_W-1:0];
               shown = {blend_chan(cfg_start[31:24], cfg_end[31:24], prog),
                        blend_chan(cfg_start[23:16], cfg_end[23:16], prog),
                        blend_chan(cfg_start[15:8],  cfg_end[15:8],  prog),
                        blend_chan(cfg_start[7:0],   cfg_end[7:0],   prog)};
            end else if (fading) begin
               shown = cfg_end;
               fading = 1'b0;
               run_ms = '0;
            end
         end
         KIND_START:      fading = 1'b1;
         KIND_PAUSE:      fading = 1'b0;
         KIND_STOP: begin
            fading = 1'b0;
            run_ms = '0;
         end
         KIND_SHOW_START: shown = cfg_start;
         KIND_SHOW_END:   shown = cfg_end;
         KIND_LOAD:       shown = color;
         default: ;
      endcase
      w.red    = shown[31:24];
      w.green  = shown[23:16];
      w.blue   = shown[15:8];
      w.alpha  = shown[7:0];
      w.fading = fading;
      return w;
   endfunction

   // elapsed step, mostly scaled to the fade length
   function automatic logic [DELTA_W-1:0] pick_delta();
      int unsigned span;
      int unsigned roll;
      span = (cfg_dur == '0) ? 1 : int'(cfg_dur) / 3 + 1;
      if (span > 65535) span = 65535;
      roll = $urandom_range(99);
      if (roll < 70) return DELTA_W'($urandom_range(span, 0));
      if (roll < 90) return DELTA_W'($urandom);
      return roll[0] ? 16'hFFFF : 16'h0000;
   endfunction

   task automatic queue_event(logic [KIND_W-1:0] kind, logic [DELTA_W-1:0] delta,
                              logic [COLOR_W-1:0] color);
      event_q.push_back('{kind, delta, color});
      n_queued++;
      phase_made++;
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_drained();
      while (n_taken != n_queued || pixel_q.size() != 0) @(negedge clock);
   endtask

   // a start, a run of ticks with the odd interruption, then a closing tick, sometimes after a maximum-step tick
   task automatic queue_fade_run();
      int unsigned ticks;
      int unsigned i;
      int unsigned roll;
      queue_event(KIND_START, DELTA_W'($urandom), $urandom);
      ticks = $urandom_range(12, 2);
      for (i = 0; i < ticks; i++) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            queue_event(KIND_PAUSE, DELTA_W'($urandom), $urandom);
            queue_event(KIND_TICK, pick_delta(), $urandom);
            queue_event(KIND_START, DELTA_W'($urandom), $urandom);
         end else if (roll < 9) begin
            queue_event(KIND_STOP, DELTA_W'($urandom), $urandom);
            queue_event(KIND_START, DELTA_W'($urandom), $urandom);
         end else if (roll < 12) begin
            queue_event(KIND_LOAD, DELTA_W'($urandom), $urandom);
         end else if (roll < 15) begin
            queue_event(KIND_SHOW_START, DELTA_W'($urandom), $urandom);
         end else if (roll < 17) begin
            queue_event(KIND_SHOW_END, DELTA_W'($urandom), $urandom);
         end
         queue_event(KIND_TICK, pick_delta(), $urandom);
      end
      if ($urandom_range(1)) queue_event(KIND_TICK, 16'hFFFF, $urandom);
      queue_event(KIND_TICK, pick_delta(), $urandom);
   endtask

   task automatic queue_random(int unsigned count);
      phase_made = 0;
      while (phase_made < count) begin
         if ($urandom_range(99) < 80) begin
            queue_fade_run();
         end else begin
            queue_event(KIND_W'($urandom_range(7, 0)), DELTA_W'($urandom), $urandom);
         end
      end
   endtask

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // input word driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_took)) begin
         if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_ev = event_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_ev.kind;
            req_tdata  <= {next_ev.color, next_ev.delta};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver with random stalls and long hold-offs on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_asks != holds_served) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor: check result words, track register writes, predict accepted words
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[32:0];
            if (pixel_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with nothing expected: %h", $time, seen);
            end else begin
               want = pixel_q.pop_front();
               if (seen.red !== want.red || seen.green !== want.green ||
                   seen.blue !== want.blue || seen.alpha !== want.alpha ||
                   seen.fading !== want.fading) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: r/g/b/a/fading expected %h/%h/%h/%h/%b got %h/%h/%h/%h/%b",
                              $time, want.red, want.green, want.blue, want.alpha, want.fading,
                              seen.red, seen.green, seen.blue, seen.alpha, seen.fading);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_COLOR: cfg_start = csr_data;
               CSR_END_COLOR:   cfg_end   = csr_data;
               CSR_DURATION:    cfg_dur   = csr_data[DUR_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pixel_q.push_back(fade_step(req_tuser, req_tdata[15:0], req_tdata[47:16]));
            n_taken++;
         end
      end
      req_took <= !reset && req_tvalid && req_tready;
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("[led_color_fade_engine] ERROR");
         $finish;
      end
   end

   // phases of register settings, idling patterns and stimulus
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 83; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         case (phase)
            1: begin
               csr_write(CSR_START_COLOR, 32'h0000_0000);
               csr_write(CSR_END_COLOR, 32'hFFFF_FFFF);
               csr_write(CSR_DURATION, 32'd1);
            end
            2: begin
               csr_write(CSR_START_COLOR, $urandom);
               csr_write(CSR_END_COLOR, $urandom);
               csr_write(CSR_DURATION, 32'd0);
            end
            3: begin
               csr_write(CSR_START_COLOR, $urandom);
               csr_write(CSR_END_COLOR, $urandom);
               csr_write(CSR_DURATION, 32'h00FF_FFFF);
            end
            4: begin
               csr_write(CSR_START_COLOR, 32'hFFFF_FFFF);
               csr_write(CSR_END_COLOR, 32'h0000_0000);
               csr_write(CSR_DURATION, $urandom_range(300, 2));
            end
            5: begin
               csr_write(CSR_SPARE, $urandom);
               csr_write(CSR_START_COLOR, $urandom);
               csr_write(CSR_END_COLOR, $urandom);
               csr_write(CSR_DURATION, $urandom_range(60000, 1000));
               csr_write(CSR_SPARE, 32'h0000_0001);
            end
            6: begin
               csr_write(CSR_START_COLOR, $urandom);
               csr_write(CSR_END_COLOR, $urandom);
               csr_write(CSR_DURATION, $urandom_range(2000, 1));
            end
            7: begin
               csr_write(CSR_START_COLOR, 32'h5AA5_C33C);
               csr_write(CSR_END_COLOR, 32'h5AA5_C33C);
               csr_write(CSR_DURATION, $urandom_range(100, 1));
            end
            default: ;
         endcase
         if (phase != 0) begin
            @(negedge clock);
            csr_valid <= 1'b0;
         end

         if (phase == 0) begin
            // directed: reset registers, idle events, fade to the end and beyond
            queue_event(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF);
            queue_event(KIND_SHOW_START, 16'h0000, 32'h0000_0000);
            queue_event(KIND_SHOW_END, 16'hFFFF, 32'hFFFF_FFFF);
            queue_event(KIND_LOAD, 16'h0000, 32'h0000_0000);
            queue_event(KIND_LOAD, 16'hFFFF, 32'hFFFF_FFFF);
            queue_event(KIND_SPARE, 16'hA5A5, 32'h1234_5678);
            queue_event(KIND_START, 16'h0000, 32'h0000_0000);
            queue_event(KIND_TICK, 16'd0, 32'h0000_0000);
            queue_event(KIND_TICK, 16'd1, 32'hFFFF_FFFF);
            queue_event(KIND_TICK, 16'd500, 32'h0000_0000);
            queue_event(KIND_PAUSE, 16'h0000, 32'h0000_0000);
            queue_event(KIND_TICK, 16'd100, 32'h0000_0000);
            queue_event(KIND_START, 16'h0000, 32'h0000_0000);
            queue_event(KIND_TICK, 16'd499, 32'h0000_0000);
            queue_event(KIND_TICK, 16'd5, 32'h0000_0000);
            queue_event(KIND_START, 16'h0000, 32'h0000_0000);
            queue_event(KIND_TICK, 16'hFFFF, 32'h0000_0000);
            queue_event(KIND_TICK, 16'd0, 32'h0000_0000);
            queue_event(KIND_START, 16'h0000, 32'h0000_0000);
            queue_event(KIND_TICK, 16'd300, 32'h0000_0000);
            queue_event(KIND_STOP, 16'hFFFF, 32'hFFFF_FFFF);
            queue_event(KIND_START, 16'h0000, 32'h0000_0000);
            queue_event(KIND_TICK, 16'd200, 32'h0000_0000);
            queue_event(KIND_LOAD, 16'h0000, 32'hA5A5_5A5A);
            queue_event(KIND_TICK, 16'hAAAA, 32'h5555_AAAA);
            wait_drained();
            // long receiver hold-off while words keep coming
            hold_asks++;
         end
         queue_random(RANDOM_PER_PHASE);
         wait_drained();
         repeat (30) @(negedge clock);
      end

      repeat (40) @(negedge clock);
      if (mismatches == 0)
         $display("[led_color_fade_engine] OK");
      else
         $display("[led_color_fade_engine] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
